// File: src/pic_pkg.sv
// Shared constants and control types of the priority interrupt controller.
`default_nettype none
package pic_pkg;

    // Line count default and fixed field widths
    localparam int NUM_LINES_DEF = 32;
    localparam int VEC_W         = 5;
    localparam int PRIO_W        = 5;
    localparam int LREG_W        = 13;
    localparam int BEST_W        = 7;
    localparam int DATA_W        = 16;
    localparam int OFF_W         = 8;
    localparam int MASK_W        = 32;
    localparam int FIQ_POS       = 8;

    // Best priority before any line is met
    localparam logic [BEST_W-1:0] NO_PRIO = 7'h7F;

    // Operation codes
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register window offsets
    localparam logic [OFF_W-1:0] OFF_LEVELS_LO  = 8'h00;
    localparam logic [OFF_W-1:0] OFF_LEVELS_HI  = 8'h02;
    localparam logic [OFF_W-1:0] OFF_MASK_LO    = 8'h08;
    localparam logic [OFF_W-1:0] OFF_MASK_HI    = 8'h0A;
    localparam logic [OFF_W-1:0] OFF_IRQ_NUM    = 8'h10;
    localparam logic [OFF_W-1:0] OFF_IRQ_NUM_A  = 8'h80;
    localparam logic [OFF_W-1:0] OFF_VEC        = 8'h12;
    localparam logic [OFF_W-1:0] OFF_VEC_A      = 8'h82;
    localparam logic [OFF_W-1:0] OFF_ACK        = 8'h14;
    localparam logic [OFF_W-1:0] OFF_ACK_A      = 8'h84;
    localparam logic [OFF_W-1:0] OFF_LREG_BASE  = 8'h20;
    localparam logic [OFF_W-1:0] OFF_LREG_END   = 8'h60;

    // Lines cleared by an IRQ_NUM read
    localparam logic [VEC_W-1:0] CLR_LINE_A = 5'd4;
    localparam logic [VEC_W-1:0] CLR_LINE_B = 5'd5;
    localparam logic [VEC_W-1:0] CLR_LINE_C = 5'd15;

    // Level register that takes its priority from another one
    localparam logic [VEC_W-1:0] LREG_COPY_SRC = 5'd4;
    localparam logic [VEC_W-1:0] LREG_COPY_DST = 5'd7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic finish;
        logic load_mem;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic arb;
        logic memrd;
        logic scan_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: src/pic_ctrl.sv
// Sequencer of the priority interrupt controller.
`default_nettype none
module pic_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire pic_pkg::t_dp_sts i_sts,
    output pic_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RDW  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Sequence one word: execute, optionally scan or wait for memory, respond
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.arb) begin
                    n_state = S_SCAN;
                end else if (i_sts.memrd) begin
                    n_state = S_RDW;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_RESP;
            end
            S_RDW: begin
                o_cmd.load_mem = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESP);

endmodule
`default_nettype wire

// File: src/pic_dp.sv
// Datapath of the priority interrupt controller: line state, level registers, scan.
`default_nettype none
module pic_dp #(
    parameter int NUM_LINES = pic_pkg::NUM_LINES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pic_pkg::t_dp_cmd                i_cmd,
    output pic_pkg::t_dp_sts                     o_sts,
    input  wire logic [1:0]                      i_op,
    input  wire logic [pic_pkg::VEC_W-1:0]       i_line,
    input  wire logic                            i_level,
    input  wire logic [pic_pkg::OFF_W-1:0]       i_offset,
    input  wire logic [pic_pkg::DATA_W-1:0]      i_wdata,
    output logic      [pic_pkg::DATA_W-1:0]      o_rdata,
    output logic                                 o_irq_out,
    output logic                                 o_fiq_out,
    output logic      [pic_pkg::VEC_W-1:0]       o_vector
);

    localparam int LW = $clog2(NUM_LINES);
    localparam logic [LW:0] NL = (LW+1)'(NUM_LINES);
    localparam logic [LW-1:0] LAST = LW'(NUM_LINES - 1);

    // Captured word
    logic [1:0]                    r_op;
    logic [pic_pkg::VEC_W-1:0]     r_line;
    logic                          r_level;
    logic [pic_pkg::OFF_W-1:0]     r_offset;
    logic [pic_pkg::DATA_W-1:0]    r_wdata;

    // Architectural state
    logic [NUM_LINES-1:0]          r_levels, n_levels;
    logic [pic_pkg::MASK_W-1:0]    r_mask, n_mask;
    logic [LW-1:0]                 r_scan_start, n_scan_start;
    logic [pic_pkg::VEC_W-1:0]     r_vector;
    logic                          r_irq, r_fiq;
    logic [pic_pkg::PRIO_W-1:0]    r_prio4, n_prio4;
    logic [NUM_LINES-1:0]          r_mvld;
    logic [pic_pkg::LREG_W-1:0]    mem [NUM_LINES];

    // Read port and scan pipeline
    logic [pic_pkg::LREG_W-1:0]    r_rd_raw;
    logic                          r_rd_vld;
    logic [LW-1:0]                 r_cnt;
    logic                          r_cvld;
    logic [LW-1:0]                 r_sidx;
    logic                          r_sact;
    logic [pic_pkg::BEST_W-1:0]    r_best_prio;
    logic [LW-1:0]                 r_best_idx;
    logic                          r_best_fiq;
    logic                          r_found;
    logic [pic_pkg::DATA_W-1:0]    r_rdata, n_rdata;

    logic                          line_ok, is_rd, is_wr, rd_irqnum, wr_mlo, wr_mhi, wr_ack;
    logic                          in_win, idx_ok, wr_lreg, clr_hit, better;
    logic [pic_pkg::OFF_W-1:0]     off_rel;
    logic [pic_pkg::VEC_W-1:0]     bus_idx;
    logic [LW:0]                   scan_sum, ack_sum;
    logic [LW-1:0]                 scan_idx, rd_addr;
    logic [NUM_LINES-1:0]          active;
    logic [pic_pkg::LREG_W-1:0]    rd_data, wr_val;
    logic [pic_pkg::MASK_W-1:0]    lv32;

    // Decode the captured word
    always_comb begin
        line_ok   = ({1'b0, r_line} < 6'(NUM_LINES));
        is_rd     = (r_op == pic_pkg::OP_READ);
        is_wr     = (r_op == pic_pkg::OP_WRITE);
        rd_irqnum = is_rd && ((r_offset == pic_pkg::OFF_IRQ_NUM) ||
                              (r_offset == pic_pkg::OFF_IRQ_NUM_A));
        wr_mlo    = is_wr && (r_offset == pic_pkg::OFF_MASK_LO);
        wr_mhi    = is_wr && (r_offset == pic_pkg::OFF_MASK_HI);
        wr_ack    = is_wr && ((r_offset == pic_pkg::OFF_ACK) ||
                              (r_offset == pic_pkg::OFF_ACK_A));
        in_win    = (r_offset >= pic_pkg::OFF_LREG_BASE) && (r_offset < pic_pkg::OFF_LREG_END);
        off_rel   = r_offset - pic_pkg::OFF_LREG_BASE;
        bus_idx   = off_rel[5:1];
        idx_ok    = ({1'b0, bus_idx} < 6'(NUM_LINES));
        wr_lreg   = is_wr && in_win && idx_ok;
        clr_hit   = (r_vector == pic_pkg::CLR_LINE_A) || (r_vector == pic_pkg::CLR_LINE_B) ||
                    (r_vector == pic_pkg::CLR_LINE_C);
    end

    assign o_sts.arb       = ((r_op == pic_pkg::OP_LINE) && line_ok) || rd_irqnum ||
                             wr_mlo || wr_mhi || wr_ack;
    assign o_sts.memrd     = is_rd && in_win && idx_ok;
    assign o_sts.scan_last = (r_cnt == LAST);

    // Circular scan index and acknowledge pointer
    always_comb begin
        scan_sum = {1'b0, r_scan_start} + {1'b0, r_cnt};
        scan_idx = (scan_sum >= NL) ? LW'(scan_sum - NL) : scan_sum[LW-1:0];
        ack_sum  = {1'b0, r_vector[LW-1:0]} + (LW+1)'(1);
        active   = r_levels & ~r_mask[NUM_LINES-1:0];
        rd_addr  = i_cmd.scan ? scan_idx : bus_idx[LW-1:0];
        rd_data  = r_rd_vld ? r_rd_raw : '0;
        lv32     = pic_pkg::MASK_W'(r_levels);
        better   = r_cvld && r_sact &&
                   ({2'b00, rd_data[pic_pkg::PRIO_W-1:0]} < r_best_prio);
        wr_val   = (bus_idx == pic_pkg::LREG_COPY_DST) ?
                   {r_wdata[pic_pkg::LREG_W-1:pic_pkg::PRIO_W], r_prio4} :
                   r_wdata[pic_pkg::LREG_W-1:0];
    end

    // Apply the side effects of the word
    always_comb begin
        n_levels     = r_levels;
        n_mask       = r_mask;
        n_scan_start = r_scan_start;
        n_prio4      = r_prio4;
        n_rdata      = r_rdata;
        if (i_cmd.exec) begin
            n_rdata = '0;
            if ((r_op == pic_pkg::OP_LINE) && line_ok) begin
                n_levels[r_line[LW-1:0]] = r_level;
            end
            if (rd_irqnum && clr_hit) begin
                n_levels[r_vector[LW-1:0]] = 1'b0;
            end
            if (wr_mlo) begin
                n_mask[15:0] = r_wdata;
            end
            if (wr_mhi) begin
                n_mask[31:16] = r_wdata;
            end
            if (wr_ack && ((r_vector != '0) || r_levels[0])) begin
                n_scan_start = (ack_sum == NL) ? '0 : ack_sum[LW-1:0];
            end
            if (wr_lreg && (bus_idx == pic_pkg::LREG_COPY_SRC)) begin
                n_prio4 = r_wdata[pic_pkg::PRIO_W-1:0];
            end
            if (is_rd) begin
                unique case (r_offset) inside
                    pic_pkg::OFF_LEVELS_LO:  n_rdata = lv32[15:0];
                    pic_pkg::OFF_LEVELS_HI:  n_rdata = lv32[31:16];
                    pic_pkg::OFF_MASK_LO:    n_rdata = r_mask[15:0];
                    pic_pkg::OFF_MASK_HI:    n_rdata = r_mask[31:16];
                    pic_pkg::OFF_IRQ_NUM, pic_pkg::OFF_IRQ_NUM_A,
                    pic_pkg::OFF_VEC, pic_pkg::OFF_VEC_A:
                                             n_rdata = pic_pkg::DATA_W'(r_vector);
                    default:                 n_rdata = '0;
                endcase
            end
        end
        if (i_cmd.load_mem) begin
            n_rdata = pic_pkg::DATA_W'(rd_data);
        end
    end

    // Hold control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels     <= '0;
            r_mask       <= '0;
            r_scan_start <= '0;
            r_prio4      <= '0;
            r_mvld       <= '0;
            r_vector     <= '0;
            r_irq        <= 1'b0;
            r_fiq        <= 1'b0;
            r_cnt        <= '0;
            r_cvld       <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_levels     <= n_levels;
            r_mask       <= n_mask;
            r_scan_start <= n_scan_start;
            r_prio4      <= n_prio4;
            r_rd_vld     <= r_mvld[rd_addr];
            r_cvld       <= i_cmd.scan;
            if (i_cmd.exec && wr_lreg) begin
                r_mvld[bus_idx[LW-1:0]] <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_cnt <= '0;
            end else if (i_cmd.scan) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + LW'(1);
            end
            if (i_cmd.finish) begin
                r_vector <= r_found ? pic_pkg::VEC_W'(r_best_idx) : '0;
                r_fiq    <= r_found && r_best_fiq;
                r_irq    <= r_found && !r_best_fiq;
            end
        end
    end

    // Level register storage with a registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_lreg) begin
            mem[bus_idx[LW-1:0]] <= wr_val;
        end
        r_rd_raw <= mem[rd_addr];
    end

    // Capture the word, track the scan and keep the best candidate
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_line   <= i_line;
            r_level  <= i_level;
            r_offset <= i_offset;
            r_wdata  <= i_wdata;
        end
        r_rdata <= n_rdata;
        r_sidx  <= scan_idx;
        r_sact  <= active[scan_idx];
        if (i_cmd.exec) begin
            r_best_prio <= pic_pkg::NO_PRIO;
            r_best_idx  <= '0;
            r_best_fiq  <= 1'b0;
            r_found     <= 1'b0;
        end else if (better) begin
            r_best_prio <= {2'b00, rd_data[pic_pkg::PRIO_W-1:0]};
            r_best_idx  <= r_sidx;
            r_best_fiq  <= rd_data[pic_pkg::FIQ_POS];
            r_found     <= 1'b1;
        end
    end

    assign o_rdata   = r_rdata;
    assign o_irq_out = r_irq;
    assign o_fiq_out = r_fiq;
    assign o_vector  = r_vector;

endmodule
`default_nettype wire

// File: src/priority_interrupt_controller_core.sv
// Top level of the priority interrupt controller.
`default_nettype none
// A word (line level change, bus read or bus write) is taken when start is high and busy is
// low; busy stays high until the single result has been shown on the o_ ports for one cycle
// with o_valid, and the receiver must take it then. A word that causes no arbitration goes
// through the execute and respond states; a level register read waits in between on the
// registered read of the level register memory. A line change, a mask write, an acknowledge
// or an IRQ_NUM read re-runs arbitration, which walks the level registers one per cycle from
// the round-robin pointer through the single memory read port.
module priority_interrupt_controller_core #(
    parameter int NUM_LINES = pic_pkg::NUM_LINES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_op,
    input  wire logic [pic_pkg::VEC_W-1:0]       i_line,
    input  wire logic                            i_level,
    input  wire logic [pic_pkg::OFF_W-1:0]       i_offset,
    input  wire logic [pic_pkg::DATA_W-1:0]      i_wdata,
    output logic                                 o_valid,
    output logic      [pic_pkg::DATA_W-1:0]      o_rdata,
    output logic                                 o_irq_out,
    output logic                                 o_fiq_out,
    output logic      [pic_pkg::VEC_W-1:0]       o_vector
);

    pic_pkg::t_dp_cmd cmd;
    pic_pkg::t_dp_sts sts;

    pic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    pic_dp #(
        .NUM_LINES (NUM_LINES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_op      (i_op),
        .i_line    (i_line),
        .i_level   (i_level),
        .i_offset  (i_offset),
        .i_wdata   (i_wdata),
        .o_rdata   (o_rdata),
        .o_irq_out (o_irq_out),
        .o_fiq_out (o_fiq_out),
        .o_vector  (o_vector)
    );

endmodule
`default_nettype wire

// File: src/pic_checker.sv
// Port-level checks of the priority interrupt controller and their binding.
`default_nettype none
module pic_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_valid,
    input wire logic                      o_irq_out,
    input wire logic                      o_fiq_out,
    input wire logic [pic_pkg::VEC_W-1:0] o_vector
);

    // A result is shown only while a word is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result shown while idle");

    // A taken word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("word taken but block not busy");

    // One result per word
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // Never both requests at once
    a_req_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_irq_out && o_fiq_out)) else $error("irq and fiq both asserted");

    // No request means no selected line
    a_idle_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_irq_out && !o_fiq_out) |-> (o_vector == '0))
        else $error("vector nonzero without a request");

endmodule

bind priority_interrupt_controller_core pic_checker u_pic_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_irq_out (o_irq_out),
    .o_fiq_out (o_fiq_out),
    .o_vector  (o_vector)
);
`default_nettype wire

// File: test/priority_interrupt_controller_core_tb.sv
// Self-checking testbench for the priority interrupt controller core.
`timescale 1ns / 100ps
module priority_interrupt_controller_core_tb;

    localparam int LINES = pic_pkg::NUM_LINES_DEF;
    localparam int RAND_WORDS = 1675;
    localparam int CALM_TAIL = 200;
    localparam int DRAIN_CYCLES = 48;

    // Codes the block does not decode
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [pic_pkg::OFF_W-1:0] OFF_NONE = 8'hFF;

    // Level register offsets used by the directed words
    localparam logic [pic_pkg::OFF_W-1:0] LREG_OFF_SRC =
        pic_pkg::OFF_LREG_BASE + pic_pkg::OFF_W'(2 * pic_pkg::LREG_COPY_SRC);
    localparam logic [pic_pkg::OFF_W-1:0] LREG_OFF_DST =
        pic_pkg::OFF_LREG_BASE + pic_pkg::OFF_W'(2 * pic_pkg::LREG_COPY_DST);
    localparam logic [pic_pkg::OFF_W-1:0] LREG_OFF_C =
        pic_pkg::OFF_LREG_BASE + pic_pkg::OFF_W'(2 * pic_pkg::CLR_LINE_C);
    localparam logic [pic_pkg::OFF_W-1:0] LREG_OFF_LAST = pic_pkg::OFF_LREG_END - 8'd1;

    typedef struct packed {
        logic [1:0]                 op;
        logic [pic_pkg::VEC_W-1:0]  line;
        logic                       level;
        logic [pic_pkg::OFF_W-1:0]  offset;
        logic [pic_pkg::DATA_W-1:0] wdata;
    } t_pic_word;

    typedef struct packed {
        logic [pic_pkg::DATA_W-1:0] rdata;
        logic                       irq;
        logic                       fiq;
        logic [pic_pkg::VEC_W-1:0]  vec;
    } t_pic_resp;

    typedef struct {
        logic [1:0]                 op;
        logic [pic_pkg::VEC_W-1:0]  line;
        logic                       level;
        logic [pic_pkg::OFF_W-1:0]  offset;
        logic [pic_pkg::DATA_W-1:0] wdata;
        bit                         chk;
        logic [pic_pkg::DATA_W-1:0] rdata;
        logic                       irq;
        logic                       fiq;
        logic [pic_pkg::VEC_W-1:0]  vec;
    } t_dir_row;

    localparam int DIR_N = 26;

    // Directed words; rows with chk set carry their own expected response
    t_dir_row dir_tab [DIR_N] = '{
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_LEVELS_LO, 16'h0000,
          1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd31, 1'b1, OFF_NONE, 16'hFFFF,
          1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_NONE, 5'd31, 1'b1, pic_pkg::OFF_ACK, 16'hFFFF,
          1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, OFF_NONE, 16'hFFFF,
          1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_ACK_A, 16'h0000,
          1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_IRQ_NUM, 16'h0000,
          1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, LREG_OFF_SRC, 16'h0003,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, LREG_OFF_DST, 16'hFFFF,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, LREG_OFF_DST + 8'd1, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, LREG_OFF_C, 16'h0103,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_LINE, pic_pkg::CLR_LINE_C, 1'b1, 8'h00, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_LINE, pic_pkg::CLR_LINE_A, 1'b1, 8'h00, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_LINE, 5'd31, 1'b1, 8'hFF, 16'hFFFF,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_LINE, 5'd0, 1'b1, 8'h00, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, pic_pkg::OFF_ACK, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_IRQ_NUM_A, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, pic_pkg::OFF_MASK_HI, 16'h8000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, pic_pkg::OFF_MASK_LO, 16'hFFFF,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_MASK_HI, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, pic_pkg::OFF_MASK_LO, 16'h0001,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_IRQ_NUM, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_WRITE, 5'd0, 1'b0, pic_pkg::OFF_ACK_A, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_VEC_A, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_LINE, pic_pkg::CLR_LINE_B, 1'b1, 8'h00, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_IRQ_NUM, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{pic_pkg::OP_READ, 5'd0, 1'b0, pic_pkg::OFF_LEVELS_HI, 16'h0000,
          1'b0, 16'h0000, 1'b0, 1'b0, 5'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_op;
    logic [pic_pkg::VEC_W-1:0] i_line;
    logic i_level;
    logic [pic_pkg::OFF_W-1:0] i_offset;
    logic [pic_pkg::DATA_W-1:0] i_wdata;
    logic o_valid;
    logic [pic_pkg::DATA_W-1:0] o_rdata;
    logic o_irq_out;
    logic o_fiq_out;
    logic [pic_pkg::VEC_W-1:0] o_vector;

    t_pic_resp resp_q [$];
    int errors = 0;

    // Controller state as predicted
    logic [31:0] lvl_st;
    logic [31:0] mask_st;
    logic [pic_pkg::LREG_W-1:0] lreg_st [LINES];
    logic [pic_pkg::VEC_W-1:0] cur_vec;
    logic [pic_pkg::VEC_W-1:0] rr_ptr;
    logic irq_st;
    logic fiq_st;

    priority_interrupt_controller_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_op     (i_op),
        .i_line   (i_line),
        .i_level  (i_level),
        .i_offset (i_offset),
        .i_wdata  (i_wdata),
        .o_valid  (o_valid),
        .o_rdata  (o_rdata),
        .o_irq_out(o_irq_out),
        .o_fiq_out(o_fiq_out),
        .o_vector (o_vector)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pick the unmasked active line with the lowest priority, scanning from the pointer
    function automatic void rearbitrate();
        logic [31:0] act;
        logic [pic_pkg::BEST_W-1:0] best;
        int idx;
        act = lvl_st & ~mask_st;
        best = pic_pkg::NO_PRIO;
        cur_vec = '0;
        irq_st = 1'b0;
        fiq_st = 1'b0;
        for (int j = 0; j < LINES; j++) begin
            idx = (int'(rr_ptr) + j) % LINES;
            if (act[idx] &&
                pic_pkg::BEST_W'(lreg_st[idx][pic_pkg::PRIO_W-1:0]) < best) begin
                best = pic_pkg::BEST_W'(lreg_st[idx][pic_pkg::PRIO_W-1:0]);
                cur_vec = pic_pkg::VEC_W'(idx);
                fiq_st = lreg_st[idx][pic_pkg::FIQ_POS];
                irq_st = !lreg_st[idx][pic_pkg::FIQ_POS];
            end
        end
    endfunction

    function automatic logic [pic_pkg::DATA_W-1:0] read_reg(logic [pic_pkg::OFF_W-1:0] off);
        logic [pic_pkg::DATA_W-1:0] val;
        int lidx;
        val = '0;
        lidx = int'(off - pic_pkg::OFF_LREG_BASE) / 2;
        case (off)
            pic_pkg::OFF_LEVELS_LO: val = lvl_st[15:0];
            pic_pkg::OFF_LEVELS_HI: val = lvl_st[31:16];
            pic_pkg::OFF_MASK_LO: val = mask_st[15:0];
            pic_pkg::OFF_MASK_HI: val = mask_st[31:16];
            pic_pkg::OFF_IRQ_NUM, pic_pkg::OFF_IRQ_NUM_A: begin
                // Return the vector, drop lines 4, 5 and 15 when selected, then re-arbitrate
                val = pic_pkg::DATA_W'(cur_vec);
                if (cur_vec == pic_pkg::CLR_LINE_A || cur_vec == pic_pkg::CLR_LINE_B ||
                    cur_vec == pic_pkg::CLR_LINE_C)
                    lvl_st[cur_vec] = 1'b0;
                rearbitrate();
            end
            pic_pkg::OFF_VEC, pic_pkg::OFF_VEC_A: val = pic_pkg::DATA_W'(cur_vec);
            pic_pkg::OFF_ACK, pic_pkg::OFF_ACK_A: val = '0;
            default: begin
                if (off >= pic_pkg::OFF_LREG_BASE && off < pic_pkg::OFF_LREG_END &&
                    lidx < LINES)
                    val = pic_pkg::DATA_W'(lreg_st[lidx]);
            end
        endcase
        return val;
    endfunction

    function automatic void write_reg(logic [pic_pkg::OFF_W-1:0] off,
                                      logic [pic_pkg::DATA_W-1:0] data);
        int lidx;
        lidx = int'(off - pic_pkg::OFF_LREG_BASE) / 2;
        case (off)
            pic_pkg::OFF_MASK_LO: begin
                mask_st[15:0] = data;
                rearbitrate();
            end
            pic_pkg::OFF_MASK_HI: begin
                mask_st[31:16] = data;
                rearbitrate();
            end
            pic_pkg::OFF_ACK, pic_pkg::OFF_ACK_A: begin
                // Advance the round-robin pointer past the acknowledged line
                if (cur_vec != '0 || lvl_st[0])
                    rr_ptr = pic_pkg::VEC_W'((int'(cur_vec) + 1) % LINES);
                rearbitrate();
            end
            default: begin
                if (off >= pic_pkg::OFF_LREG_BASE && off < pic_pkg::OFF_LREG_END &&
                    lidx < LINES) begin
                    lreg_st[lidx] = data[pic_pkg::LREG_W-1:0];
                    if (lidx == int'(pic_pkg::LREG_COPY_DST))
                        lreg_st[lidx][pic_pkg::PRIO_W-1:0] =
                            lreg_st[pic_pkg::LREG_COPY_SRC][pic_pkg::PRIO_W-1:0];
                end
            end
        endcase
    endfunction

    function automatic t_pic_resp predict_word(t_pic_word w);
        t_pic_resp r;
        r = '0;
        case (w.op)
            pic_pkg::OP_LINE: begin
                if (int'(w.line) < LINES) begin
                    lvl_st[w.line] = w.level;
                    rearbitrate();
                end
            end
            pic_pkg::OP_READ: r.rdata = read_reg(w.offset);
            pic_pkg::OP_WRITE: write_reg(w.offset, w.wdata);
            default: ;
        endcase
        r.irq = irq_st;
        r.fiq = fiq_st;
        r.vec = cur_vec;
        return r;
    endfunction

    // Build a random word, mostly well-formed accesses with small priorities so ties occur
    function automatic t_pic_word roll_word();
        t_pic_word w;
        int pick;
        int sel;
        w.op = pic_pkg::OP_LINE;
        w.line = pic_pkg::VEC_W'($urandom);
        w.level = ($urandom_range(0, 9) < 6);
        w.offset = pic_pkg::OFF_W'($urandom);
        w.wdata = pic_pkg::DATA_W'($urandom);
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        if (pick < 40) begin
            w.op = pic_pkg::OP_LINE;
        end else if (pick < 65) begin
            w.op = pic_pkg::OP_READ;
            if (sel < 7) begin
                case ($urandom_range(0, 10))
                    0: w.offset = pic_pkg::OFF_LEVELS_LO;
                    1: w.offset = pic_pkg::OFF_LEVELS_HI;
                    2: w.offset = pic_pkg::OFF_MASK_LO;
                    3: w.offset = pic_pkg::OFF_MASK_HI;
                    4, 5: w.offset = pic_pkg::OFF_IRQ_NUM;
                    6: w.offset = pic_pkg::OFF_IRQ_NUM_A;
                    7: w.offset = pic_pkg::OFF_VEC;
                    8: w.offset = pic_pkg::OFF_VEC_A;
                    9: w.offset = ($urandom_range(0, 1) != 0) ? pic_pkg::OFF_ACK :
                                                               pic_pkg::OFF_ACK_A;
                    default: w.offset = pic_pkg::OFF_LREG_BASE +
                                        pic_pkg::OFF_W'($urandom_range(0, 63));
                endcase
            end
        end else if (pick < 97) begin
            w.op = pic_pkg::OP_WRITE;
            if (sel < 5) begin
                w.offset = pic_pkg::OFF_LREG_BASE + pic_pkg::OFF_W'($urandom_range(0, 63));
                if ($urandom_range(0, 9) < 6)
                    w.wdata[pic_pkg::PRIO_W-1:0] = pic_pkg::PRIO_W'($urandom_range(0, 3));
            end else if (sel < 7) begin
                w.offset = ($urandom_range(0, 1) != 0) ? pic_pkg::OFF_ACK : pic_pkg::OFF_ACK_A;
            end else if (sel < 9) begin
                w.offset = ($urandom_range(0, 1) != 0) ? pic_pkg::OFF_MASK_LO :
                                                         pic_pkg::OFF_MASK_HI;
                case ($urandom_range(0, 9))
                    0: w.wdata = '0;
                    1, 2: ;
                    default: w.wdata = pic_pkg::DATA_W'($urandom & $urandom & $urandom);
                endcase
            end
        end else begin
            w.op = OP_NONE;
        end
        return w;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Present a word, hold it until taken, then queue the response it should cause
    task automatic issue_word(t_pic_word w, bit chk, t_pic_resp typed);
        t_pic_resp p;
        start <= 1'b1;
        i_op <= w.op;
        i_line <= w.line;
        i_level <= w.level;
        i_offset <= w.offset;
        i_wdata <= w.wdata;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        p = predict_word(w);
        resp_q.push_back(chk ? typed : p);
    endtask

    task automatic rest(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Compare each response word with the oldest expectation
    always @(posedge i_clk) begin
        t_pic_resp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (resp_q.size() == 0) begin
                flag_mismatch("unexpected word, vector", o_vector, 0);
            end else begin
                want = resp_q.pop_front();
                if (o_rdata !== want.rdata) flag_mismatch("rdata", o_rdata, want.rdata);
                if (o_irq_out !== want.irq) flag_mismatch("irq_out", o_irq_out, want.irq);
                if (o_fiq_out !== want.fiq) flag_mismatch("fiq_out", o_fiq_out, want.fiq);
                if (o_vector !== want.vec) flag_mismatch("vector", o_vector, want.vec);
            end
        end
    end

    // Stimulus: reset, directed table, then random words
    initial begin
        t_pic_word w;
        t_pic_resp t;
        int idle_pct;
        idle_pct = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_op <= pic_pkg::OP_LINE;
        i_line <= '0;
        i_level <= 1'b0;
        i_offset <= '0;
        i_wdata <= '0;
        lvl_st = '0;
        mask_st = '0;
        for (int n = 0; n < LINES; n++)
            lreg_st[n] = '0;
        cur_vec = '0;
        rr_ptr = '0;
        irq_st = 1'b0;
        fiq_st = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            w = '{dir_tab[k].op, dir_tab[k].line, dir_tab[k].level, dir_tab[k].offset,
                  dir_tab[k].wdata};
            t = '{dir_tab[k].rdata, dir_tab[k].irq, dir_tab[k].fiq, dir_tab[k].vec};
            issue_word(w, dir_tab[k].chk, t);
            if ($urandom_range(0, 3) == 0)
                rest($urandom_range(1, 14));
        end

        for (int k = 0; k < RAND_WORDS; k++) begin
            // Vary the idle density per segment, none toward the end
            if (k % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    2: idle_pct = 30;
                    default: idle_pct = 60;
                endcase
            end
            issue_word(roll_word(), 1'b0, '0);
            if (k < RAND_WORDS - CALM_TAIL && $urandom_range(0, 99) < idle_pct)
                rest($urandom_range(1, 14));
        end
        start <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (resp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("priority_interrupt_controller_core test passed");
        end else begin
            $display("priority_interrupt_controller_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("priority_interrupt_controller_core test failed");
        $finish;
    end

endmodule
